>>> rtl/igm_pkg.sv
package igm_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam logic [31:0] MIN_MAG_RESET = 32'd66;
endpackage

>>> rtl/igm_if.sv
interface igm_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] grad_x;
   logic signed [DATA_WIDTH-1:0] grad_y;
   logic                         last_in;
   modport source (output valid, grad_x, grad_y, last_in, input ready);
   modport sink   (input valid, grad_x, grad_y, last_in, output ready);
endinterface

interface igm_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] magnitude;
   logic [DATA_WIDTH-1:0] recip;
   logic [DATA_WIDTH-1:0] recip_cubed;
   logic                  clamped;
   logic                  last_out;
   modport source (output valid, magnitude, recip, recip_cubed, clamped, last_out,
                   input ready);
   modport sink   (input valid, magnitude, recip, recip_cubed, clamped, last_out,
                   output ready);
endinterface

interface igm_csr_if #(parameter int DATA_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> rtl/igm_sqrt_cell.sv
module igm_sqrt_cell
   import igm_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int STEP       = 0,
   parameter int TAG_W      = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    valid_in,
   input  logic [2*DATA_WIDTH-1:0] rem_in,
   input  logic [DATA_WIDTH-1:0]   root_in,
   input  logic [TAG_W-1:0]        tag_in,
   output logic                    valid_out,
   output logic [2*DATA_WIDTH-1:0] rem_out,
   output logic [DATA_WIDTH-1:0]   root_out,
   output logic [TAG_W-1:0]        tag_out
);
   localparam int XW = 2*DATA_WIDTH + 1;

   logic                    valid_ff;
   logic [2*DATA_WIDTH-1:0] rem_ff, rem_in_c;
   logic [DATA_WIDTH-1:0]   root_ff, root_in_c;
   logic [TAG_W-1:0]        tag_ff;
   logic [XW-1:0]           trial, rem_x;

   always_comb begin
      trial = (XW'(root_in) << (STEP + 1)) | (XW'(1) << (2*STEP));
      rem_x = XW'(rem_in);
      if (rem_x >= trial) begin
         rem_in_c  = (2*DATA_WIDTH)'(rem_x - trial);
         root_in_c = root_in | (DATA_WIDTH'(1) << STEP);
      end else begin
         rem_in_c  = rem_in;
         root_in_c = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         rem_ff  <= rem_in_c;
         root_ff <= root_in_c;
         tag_ff  <= tag_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign tag_out   = tag_ff;
endmodule

>>> rtl/igm_div_cell.sv
module igm_div_cell
   import igm_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int QW         = 33,
   parameter int STEP       = 0,
   parameter int TAG_W      = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  valid_in,
   input  logic [DATA_WIDTH-1:0] div_in,
   input  logic [DATA_WIDTH-1:0] rem_in,
   input  logic [QW-1:0]         quot_in,
   input  logic [TAG_W-1:0]      tag_in,
   output logic                  valid_out,
   output logic [DATA_WIDTH-1:0] div_out,
   output logic [DATA_WIDTH-1:0] rem_out,
   output logic [QW-1:0]         quot_out,
   output logic [TAG_W-1:0]      tag_out
);
   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] div_ff, rem_ff, rem_in_c;
   logic [QW-1:0]         quot_ff, quot_in_c;
   logic [TAG_W-1:0]      tag_ff;
   logic [DATA_WIDTH:0]   shifted, dsor;

   // dividend is a single one at the top quotient bit
   always_comb begin
      shifted = {rem_in, (STEP == QW - 1) ? 1'b1 : 1'b0};
      dsor    = {1'b0, div_in};
      if (shifted >= dsor) begin
         rem_in_c  = DATA_WIDTH'(shifted - dsor);
         quot_in_c = quot_in | (QW'(1) << STEP);
      end else begin
         rem_in_c  = DATA_WIDTH'(shifted);
         quot_in_c = quot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         div_ff  <= div_in;
         rem_ff  <= rem_in_c;
         quot_ff <= quot_in_c;
         tag_ff  <= tag_in;
      end
   end

   assign valid_out = valid_ff;
   assign div_out   = div_ff;
   assign rem_out   = rem_ff;
   assign quot_out  = quot_ff;
   assign tag_out   = tag_ff;
endmodule

>>> rtl/inverse_gradient_magnitude.sv
// channel | dir | signals
// req     | in  | valid ready grad_x grad_y last_in
// rsp     | out | valid ready magnitude recip recip_cubed clamped last_out
// csr     | in  | valid ready data (min_magnitude)
// One item per cycle while rsp is not stalled; the pipeline holds one
// square-root cell per result bit and one divider cell per quotient bit.
// Reset clears all valid bits and loads min_magnitude = 66.
// A stalled rsp freezes the whole chain; req.ready drops only then.
module inverse_gradient_magnitude
   import igm_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   igm_req_if.sink   req,
   igm_rsp_if.source rsp,
   igm_csr_if.sink   csr
);
   localparam int W   = DATA_WIDTH;
   localparam int QW  = 2*FRAC_BITS + 1;
   localparam int XW  = (QW > W) ? QW : W + 1;
   localparam int SW  = 2*W - FRAC_BITS;
   localparam int DTG = W + 2;

   logic         enable;
   logic [W-1:0] min_ff;

   assign enable    = !rsp.valid || rsp.ready;
   assign req.ready = enable;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= W'(MIN_MAG_RESET);
      end else if (csr.valid) begin
         min_ff <= csr.data;
      end
   end

   // absolute values, squares and their sum
   logic [W-1:0]   ax, ay;
   logic           v1_ff, v2_ff;
   logic [2*W-1:0] sqx_ff, sqy_ff, sum_ff;
   logic           l1_ff, l2_ff;

   assign ax = req.grad_x[W-1] ? W'(-req.grad_x) : W'(req.grad_x);
   assign ay = req.grad_y[W-1] ? W'(-req.grad_y) : W'(req.grad_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
      end
      if (enable) begin
         sqx_ff <= (2*W)'(ax) * (2*W)'(ax);
         sqy_ff <= (2*W)'(ay) * (2*W)'(ay);
         l1_ff  <= req.last_in;
         sum_ff <= sqx_ff + sqy_ff;
         l2_ff  <= l1_ff;
      end
   end

   // square-root chain, one result bit per cell, top bit first
   logic           sv [0:W];
   logic [2*W-1:0] srem [0:W];
   logic [W-1:0]   sroot [0:W];
   logic           stag [0:W];

   assign sv[0]    = v2_ff;
   assign srem[0]  = sum_ff;
   assign sroot[0] = '0;
   assign stag[0]  = l2_ff;

   for (genvar i = 0; i < W; i++) begin : g_sqrt
      igm_sqrt_cell #(.DATA_WIDTH(W), .STEP(W - 1 - i), .TAG_W(1)) u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(sv[i]), .rem_in(srem[i]), .root_in(sroot[i]), .tag_in(stag[i]),
         .valid_out(sv[i+1]), .rem_out(srem[i+1]), .root_out(sroot[i+1]),
         .tag_out(stag[i+1])
      );
   end

   // clamp
   logic         v3_ff, cl3_ff, l3_ff;
   logic [W-1:0] mag3_ff, div3_ff, minv;
   logic         clamp_c;

   assign minv    = (min_ff == '0) ? W'(1) : min_ff;
   assign clamp_c = sroot[W] < minv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= sv[W];
      end
      if (enable) begin
         mag3_ff <= sroot[W];
         div3_ff <= clamp_c ? minv : sroot[W];
         cl3_ff  <= clamp_c;
         l3_ff   <= stag[W];
      end
   end

   // divider chain, one quotient bit per cell, top bit first
   logic           dv [0:QW];
   logic [W-1:0]   ddiv [0:QW];
   logic [W-1:0]   drem [0:QW];
   logic [QW-1:0]  dquot [0:QW];
   logic [DTG-1:0] dtag [0:QW];

   assign dv[0]    = v3_ff;
   assign ddiv[0]  = div3_ff;
   assign drem[0]  = '0;
   assign dquot[0] = '0;
   assign dtag[0]  = {mag3_ff, cl3_ff, l3_ff};

   for (genvar i = 0; i < QW; i++) begin : g_div
      igm_div_cell #(.DATA_WIDTH(W), .QW(QW), .STEP(QW - 1 - i), .TAG_W(DTG)) u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(dv[i]), .div_in(ddiv[i]), .rem_in(drem[i]), .quot_in(dquot[i]),
         .tag_in(dtag[i]),
         .valid_out(dv[i+1]), .div_out(ddiv[i+1]), .rem_out(drem[i+1]),
         .quot_out(dquot[i+1]), .tag_out(dtag[i+1])
      );
   end

   // reciprocal saturation and cube
   logic [XW-1:0]  qx;
   logic [W-1:0]   rec_c;
   logic           v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic [DTG-1:0] t4_ff, t5_ff, t6_ff, t7_ff;
   logic [W-1:0]   r4_ff, r5_ff, r6_ff, r7_ff;
   logic [2*W-1:0] p5_ff, p7_ff;
   logic [SW-1:0]  s6;
   logic [W-1:0]   s6_ff;
   logic           o6_ff, o7_ff;
   logic [2*W-1:0] t8;
   logic [W-1:0]   cube_c;
   logic [W-1:0]   mag_ff, rec_ff, cube_ff;
   logic           cl_ff, last_ff;

   assign qx    = XW'(dquot[QW]);
   assign rec_c = (qx > XW'({W{1'b1}})) ? '1 : W'(dquot[QW]);
   assign s6    = SW'(p5_ff >> FRAC_BITS);
   assign t8    = p7_ff >> FRAC_BITS;
   assign cube_c = (o7_ff || (t8 >> W) != '0) ? '1 : W'(t8);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (enable) begin
         v4_ff <= dv[QW];
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
      if (enable) begin
         r4_ff   <= rec_c;
         t4_ff   <= dtag[QW];
         p5_ff   <= (2*W)'(r4_ff) * (2*W)'(r4_ff);
         r5_ff   <= r4_ff;
         t5_ff   <= t4_ff;
         s6_ff   <= W'(s6);
         o6_ff   <= (s6 >> W) != '0;
         r6_ff   <= r5_ff;
         t6_ff   <= t5_ff;
         p7_ff   <= (2*W)'(s6_ff) * (2*W)'(r6_ff);
         o7_ff   <= o6_ff;
         r7_ff   <= r6_ff;
         t7_ff   <= t6_ff;
         cube_ff <= cube_c;
         rec_ff  <= r7_ff;
         mag_ff  <= t7_ff[DTG-1:2];
         cl_ff   <= t7_ff[1];
         last_ff <= t7_ff[0];
      end
   end

   assign rsp.valid       = v8_ff;
   assign rsp.magnitude   = mag_ff;
   assign rsp.recip       = rec_ff;
   assign rsp.recip_cubed = cube_ff;
   assign rsp.clamped     = cl_ff;
   assign rsp.last_out    = last_ff;
endmodule

>>> verif/tb_inverse_gradient_magnitude.sv
`timescale 1ns / 1ps
module tb_inverse_gradient_magnitude;
   import igm_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = DW + 2*FB + 9;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [DW-1:0] magnitude;
      logic [DW-1:0] recip;
      logic [DW-1:0] recip_cubed;
      logic          clamped;
      logic          last_out;
   } igm_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   igm_req_if #(.DATA_WIDTH(DW)) req_if ();
   igm_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();
   igm_csr_if #(.DATA_WIDTH(DW)) csr_if ();

   inverse_gradient_magnitude #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr(csr_if.sink)
   );

   always #4 clock = ~clock;

   igm_result_type expected_results[$];
   logic [DW-1:0] min_mag_model;
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;
   int  receiver_holdoff = 0;

   function automatic logic [DW-1:0] abs_grad(logic [DW-1:0] raw);
      return raw[DW-1] ? (~raw + 1'b1) : raw;
   endfunction

   function automatic logic [DW-1:0] isqrt(logic [2*DW:0] v);
      logic [DW-1:0] r;
      logic [DW-1:0] cand;
      r = '0;
      for (int b = DW-1; b >= 0; b--) begin
         cand = r | (DW'(1) << b);
         if ({{(DW+1){1'b0}}, cand} * {{(DW+1){1'b0}}, cand} <= {1'b0, v}) r = cand;
      end
      return r;
   endfunction

   function automatic igm_result_type predict_gradient(logic [DW-1:0] gx,
                                                       logic [DW-1:0] gy, logic last);
      igm_result_type res;
      logic [DW-1:0] ax, ay, minv, divisor;
      logic [2*DW:0] sum;
      logic [4*DW-1:0] rec, sq, cube;
      ax = abs_grad(gx);
      ay = abs_grad(gy);
      sum = (2*DW+1)'(ax) * (2*DW+1)'(ax) + (2*DW+1)'(ay) * (2*DW+1)'(ay);
      res.magnitude = isqrt(sum);
      minv = (min_mag_model == '0) ? DW'(1) : min_mag_model;
      res.clamped = res.magnitude < minv;
      divisor = res.clamped ? minv : res.magnitude;
      rec = ((4*DW)'(1) << (2*FB)) / (4*DW)'(divisor);
      if (rec > (4*DW)'({DW{1'b1}})) rec = (4*DW)'({DW{1'b1}});
      res.recip = rec[DW-1:0];
      sq = (rec * rec) >> FB;
      cube = (sq * rec) >> FB;
      res.recip_cubed = (cube > (4*DW)'({DW{1'b1}})) ? {DW{1'b1}} : cube[DW-1:0];
      res.last_out = last;
      return res;
   endfunction

   task automatic send_gradient(logic [DW-1:0] gx, logic [DW-1:0] gy, logic last);
      while (sender_idles && $urandom_range(99) < 21) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.grad_x  <= gx;
      req_if.grad_y  <= gy;
      req_if.last_in <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_results.push_back(predict_gradient(gx, gy, last));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_min_magnitude(logic [DW-1:0] value);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      min_mag_model = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [DW-1:0] random_grad();
      unique case ($urandom_range(5))
         0: return $urandom_range(255);
         1: return -DW'($urandom_range(255));
         2: return DW'($urandom_range(32'h3FFFF)) - DW'(32'h1FFFF);
         3: return {DW{1'b1}} ^ DW'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [DW-1:0] edge_vals[10];
      edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0001_0000, 32'hFFFF_0000, 32'h42, 32'h41, 32'h43};
      foreach (edge_vals[i]) send_gradient(edge_vals[i], edge_vals[9-i], i[0]);
      send_gradient(32'h8000_0000, 32'h8000_0000, 1'b1);
      send_gradient(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_gradient(32'h0000_0003, 32'h0000_0004, 1'b1);
      send_gradient(32'hFFFF_FFFD, 32'h0000_0004, 1'b0);
      send_gradient(32'h0000_0100, 32'h0, 1'b1);
      send_gradient(32'h0, 32'h0000_00FF, 1'b0);
   endtask

   task automatic test_random(int count);
      repeat (count) send_gradient(random_grad(), random_grad(), $urandom_range(1));
   endtask

   task automatic test_backpressure();
      receiver_holdoff = 300;
      sender_idles = 1'b0;
      test_random(150);
      sender_idles = 1'b1;
      wait_drained();
   endtask

   task automatic test_min_settings();
      logic [DW-1:0] settings[6];
      settings = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'd66};
      foreach (settings[i]) begin
         write_min_magnitude(settings[i]);
         send_gradient(32'h0, 32'h0, 1'b0);
         send_gradient(settings[i], 32'h0, 1'b1);
         send_gradient(settings[i] - 1'b1, 32'h0, 1'b0);
         test_random(40);
      end
   endtask

   task automatic test_no_idle();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      test_random(150);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else if (receiver_holdoff > 0) begin
         receiver_holdoff <= receiver_holdoff - 1;
         rsp_if.ready <= 1'b0;
      end else rsp_if.ready <= !(receiver_idles && $urandom_range(99) < 21);
   end

   always @(posedge clock) begin
      igm_result_type exp_res;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result magnitude=%h", rsp_if.magnitude);
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_if.magnitude !== exp_res.magnitude) begin
               $error("magnitude exp %h got %h", exp_res.magnitude, rsp_if.magnitude);
               error_count++;
            end
            if (rsp_if.recip !== exp_res.recip) begin
               $error("recip exp %h got %h", exp_res.recip, rsp_if.recip);
               error_count++;
            end
            if (rsp_if.recip_cubed !== exp_res.recip_cubed) begin
               $error("recip_cubed exp %h got %h", exp_res.recip_cubed, rsp_if.recip_cubed);
               error_count++;
            end
            if (rsp_if.clamped !== exp_res.clamped) begin
               $error("clamped exp %b got %b", exp_res.clamped, rsp_if.clamped);
               error_count++;
            end
            if (rsp_if.last_out !== exp_res.last_out) begin
               $error("last_out exp %b got %b", exp_res.last_out, rsp_if.last_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.grad_x  = '0;
      req_if.grad_y  = '0;
      req_if.last_in = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.data    = '0;
      min_mag_model  = MIN_MAG_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(150);
      test_backpressure();
      test_min_settings();
      test_no_idle();
      wait_drained();
      if (error_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
